>>> rtl/core/bbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg: shared definitions for the binary boundary extractor
// Frame size limits, command and register codes, and the result word type.
// ----------------------------------------------------------------------------
package bbe_pkg;

    // Frame size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;

    // Column index width and the width of size registers and row counter
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int DIM_W = 11;

    // Reset frame size
    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(10);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(5);

    // Input word kinds carried in tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // One result word
    typedef struct packed {
        logic last_of_frame;
        logic eroded;
        logic boundary;
    } t_result;

endpackage

>>> rtl/core/bbe_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_skid: output register with skid stage
// Holds up to two result words so that the upstream ready is a register and
// a new word can be taken while a finished one waits downstream.
// ----------------------------------------------------------------------------
module bbe_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bbe_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop_ready,
    output bbe_pkg::t_result o_data
);
    import bbe_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid & i_pop_ready;
    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves without reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || pop) begin
            if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

>>> rtl/core/binary_boundary_extract_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_boundary_extract_3x3: morphological boundary of a binary image
// Gives each pixel's 3x3 erosion and the pixel AND NOT its erosion.
// ----------------------------------------------------------------------------
// Binary pixels enter in raster order, one word per clock, and the block takes
// a word in every cycle as long as the output side keeps up; a two-word output
// stage lets it take a word while a result waits. Each pixel's result leaves
// image_width+1 accepted words after the pixel entered, through the output
// register; after the last pixel of a frame send image_width+1 drain words to
// push out the rest. The two previous rows live in one MAX_WIDTH x 2 bit
// memory whose read for the next column is issued ahead from the next-position
// address, so the memory port sets no limit on rate. Border pixels are never
// eroded. Writing either size register (values are clamped to 3..1024) restarts
// the frame; a drain word before all pixels are in is dropped without a result.
module binary_boundary_extract_3x3 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [bbe_pkg::DIM_W-1:0]   i_cfg_data,
    // Input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [0] pixel_in
    input  logic                        s_axis_tuser,  // [0] command
    // Result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,  // [0] boundary, [1] eroded
    output logic                        m_axis_tlast
);
    import bbe_pkg::*;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [COL_W-1:0] r_col;
    logic [DIM_W-1:0] r_row;
    logic [8:0]       r_win;
    logic [1:0]       r_lb [MAX_WIDTH];
    logic [1:0]       r_lb_rd;

    logic [COL_W-1:0] n_col;
    logic [DIM_W-1:0] n_row;
    logic [8:0]       n_win;

    logic             accept;
    logic             done;
    logic             act;
    logic             pix;
    logic             emit;
    logic             is_last;
    logic             ero;
    logic             row_end;
    logic [DIM_W-1:0] col_plus;
    logic [DIM_W-1:0] clamped_w;
    logic [DIM_W-1:0] clamped_h;
    t_result          res;
    t_result          out_res;

    // Clamp the written value into the legal frame size range
    always_comb begin
        if (i_cfg_data < DIM_W'(MIN_DIM)) begin
            clamped_w = DIM_W'(MIN_DIM);
        end else if (i_cfg_data > DIM_W'(MAX_WIDTH)) begin
            clamped_w = DIM_W'(MAX_WIDTH);
        end else begin
            clamped_w = i_cfg_data;
        end
        if (i_cfg_data < DIM_W'(MIN_DIM)) begin
            clamped_h = DIM_W'(MIN_DIM);
        end else if (i_cfg_data > DIM_W'(MAX_HEIGHT)) begin
            clamped_h = DIM_W'(MAX_HEIGHT);
        end else begin
            clamped_h = i_cfg_data;
        end
    end

    // A word does work unless it is a drain while pixels are still due
    assign accept  = s_axis_tvalid & s_axis_tready;
    assign done    = (r_row >= r_height);
    assign act     = accept & ((s_axis_tuser == CMD_PIXEL) | done);
    assign pix     = done ? 1'b0 : s_axis_tdata[0];

    // Shift the new column into the window: upper, middle, current row
    assign n_win   = {pix, r_lb_rd[1], r_lb_rd[0], r_win[8:3]};

    // The window centre is the pixel that entered image_width+1 words ago
    assign emit    = act & ((r_row >= DIM_W'(2)) ||
                     ((r_row == DIM_W'(1)) && (r_col != '0)));
    assign is_last = (r_col == '0) && (r_row == DIM_W'(r_height + DIM_W'(1)));
    assign ero     = (r_col >= COL_W'(2)) && (r_row >= DIM_W'(2)) &&
                     (r_row < r_height) && (&n_win);

    assign res.boundary      = n_win[4] & ~ero;
    assign res.eroded        = ero;
    assign res.last_of_frame = is_last;

    // Next raster position
    assign col_plus = DIM_W'(r_col) + DIM_W'(1);
    assign row_end  = (col_plus >= r_width);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we || (emit && is_last)) begin
            n_col = '0;
            n_row = '0;
        end else if (act) begin
            if (row_end) begin
                n_col = '0;
                n_row = DIM_W'(r_row + DIM_W'(1));
            end else begin
                n_col = col_plus[COL_W-1:0];
            end
        end
    end

    // Frame size registers, position counters and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
            r_win    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IMAGE_WIDTH) begin
                    r_width <= clamped_w;
                end else begin
                    r_height <= clamped_h;
                end
                r_win <= '0;
            end else if (emit && is_last) begin
                r_win <= '0;
            end else if (act) begin
                r_win <= n_win;
            end
        end
    end

    // Line buffer memory: bit 1 is the previous row, bit 0 the one above it.
    // The read for the next column is registered ahead, from the next-position address.
    always_ff @(posedge i_clk) begin
        if (act) begin
            r_lb[r_col] <= {pix, r_lb_rd[1]};
        end
        r_lb_rd <= r_lb[n_col];
    end

    // Output stage
    bbe_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (emit),
        .i_data      (res),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_data      (out_res)
    );

    assign m_axis_tdata = {6'b0, out_res.eroded, out_res.boundary};
    assign m_axis_tlast = out_res.last_of_frame;

`ifndef SYNTHESIS
    // The column counter always stays inside the current row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_col) < r_width)
        else $error("column counter beyond image width");

    // Rows run at most to the last drain row
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= DIM_W'(r_height + DIM_W'(1)))
        else $error("row counter beyond drain row");

    // Input held off only while results are queued downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // The final pixel of a frame is a corner and is never eroded
    a_last_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[1])
        else $error("frame corner reported as eroded");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream check of the 3x3 binary boundary extractor
// Feeds binary frames of many sizes, with drain words and noise words, into
// the block, predicts every result word from its own model of the line
// buffers and the 3x3 window, and compares each result word field by field.
// ----------------------------------------------------------------------------
module testbench;

    import bbe_pkg::*;

    localparam int SETTLE_CYCLES = 16;

    // One input word as it leaves the pending queue
    typedef struct packed {
        logic cmd;
        logic pix;
    } pix_word_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = CFG_IMAGE_WIDTH;
    logic [DIM_W-1:0]   i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;    // [0] pixel_in
    logic               s_axis_tuser = CMD_PIXEL;  // [0] command
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;         // [0] boundary, [1] eroded
    logic               m_axis_tlast;

    binary_boundary_extract_3x3 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Stimulus and expectation stores
    pix_word_t  pending_words[$];
    t_result    expected_results[$];
    pix_word_t  sent_word;
    int         gap_pct = 27;
    int         stall_pct = 27;
    int         mismatch_count = 0;
    int         random_items = 0;

    // Shadow of the block: size registers, two previous rows, window, position
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               lb_upper [MAX_WIDTH];
    logic               lb_middle [MAX_WIDTH];
    logic [8:0]         win_bits;
    int                 col_pos;
    int                 row_pos;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    task automatic restart_frame();
        win_bits = '0;
        col_pos  = 0;
        row_pos  = 0;
    endtask

    // Advance the shadow by one accepted word and queue the result it causes.
    task automatic predict_boundary(input pix_word_t wd);
        int         w, h, c, r, t, pr, pc;
        logic       v;
        logic       ero;
        t_result    res;
        bit         done;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        done = (row_pos >= h);
        // A drain word while pixels are still due is dropped.
        if (wd.cmd == CMD_DRAIN && !done) return;
        c = col_pos;
        r = row_pos;
        // Once the frame's pixels are all in, every word acts as a drain step.
        v = done ? 1'b0 : wd.pix;
        win_bits = {v, lb_middle[c], lb_upper[c], win_bits[8:3]};
        lb_upper[c]  = lb_middle[c];
        lb_middle[c] = v;
        t = r * w + c;
        if (c + 1 < w) begin
            col_pos = c + 1;
        end else begin
            col_pos = 0;
            row_pos = r + 1;
        end
        if (t < w + 1) return;
        // The window center is the pixel that entered w+1 slots ago.
        if (c >= 1) begin
            pr = r - 1;
            pc = c - 1;
        end else begin
            pr = r - 2;
            pc = w - 1;
        end
        ero = (pr >= 1 && pr + 2 <= h && pc >= 1 && pc + 2 <= w) && (win_bits == 9'h1FF);
        res.boundary      = win_bits[4] & ~ero;
        res.eroded        = ero;
        res.last_of_frame = (pr == h - 1 && pc == w - 1);
        expected_results.push_back(res);
        if (res.last_of_frame) restart_frame();
    endtask

    // Driver: moves words from the pending queue onto the input stream.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_boundary(sent_word);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= gap_pct) begin
                    sent_word = pending_words.pop_front();
                    s_axis_tdata  <= {7'b0, sent_word.pix};
                    s_axis_tuser  <= sent_word.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata[1], m_axis_tdata[0]};
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with no prediction waiting");
                end else begin
                    want = expected_results.pop_front();
                    if (got.boundary !== want.boundary)
                        report_mismatch($sformatf("boundary %b, expected %b",
                                                  got.boundary, want.boundary));
                    if (got.eroded !== want.eroded)
                        report_mismatch($sformatf("eroded %b, expected %b",
                                                  got.eroded, want.eroded));
                    if (got.last_of_frame !== want.last_of_frame)
                        report_mismatch($sformatf("last_of_frame %b, expected %b",
                                                  got.last_of_frame, want.last_of_frame));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_word(input logic cmd, input logic pix);
        pending_words.push_back({cmd, pix});
    endtask

    // Wait until every word is taken and every result is in, then let the
    // pipeline settle so that no word still in flight is cut by a write.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        restart_frame();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Queue one frame with random content and stray drain words; a cut frame
    // stops part way so that the next register write must restart it.
    task automatic push_frame(input int w, input int h, input bit cut);
        int n_pix;
        int ones_pct;
        case ($urandom_range(5))
            0: ones_pct = 0;
            1: ones_pct = 50;
            2: ones_pct = 80;
            3: ones_pct = 100;
            default: ones_pct = 92;
        endcase
        n_pix = cut ? $urandom_range(w * h - 1, w + 2) : w * h;
        for (int i = 0; i < n_pix; i++) begin
            if ($urandom_range(99) < 4) push_word(CMD_DRAIN, $urandom_range(1));
            push_word(CMD_PIXEL, $urandom_range(99) < ones_pct);
            random_items++;
        end
        if (!cut) begin
            // Pixel words past the frame end act as drain steps.
            for (int d = 0; d <= w; d++) begin
                if ($urandom_range(99) < 20) push_word(CMD_PIXEL, $urandom_range(1));
                else push_word(CMD_DRAIN, $urandom_range(1));
                random_items++;
            end
            if ($urandom_range(3) == 0) push_word(CMD_DRAIN, $urandom_range(1));
        end
    endtask

    initial begin
        int wv, hv, n_frames;
        width_reg  = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        for (int k = 0; k < MAX_WIDTH; k++) begin
            lb_upper[k]  = 1'b0;
            lb_middle[k] = 1'b0;
        end
        restart_frame();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset size: a partial frame of ones, later cut by the size writes.
        for (int k = 0; k < 13; k++) push_word(CMD_PIXEL, 1'b1);
        wait_drained();

        // Smallest frame, all ones: only the center erodes.
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(3));
        write_reg(CFG_IMAGE_HEIGHT, DIM_W'(3));
        @(negedge i_clk);
        push_word(CMD_DRAIN, 1'b1);
        for (int k = 0; k < 4; k++) push_word(CMD_PIXEL, 1'b1);
        push_word(CMD_DRAIN, 1'b0);
        for (int k = 0; k < 5; k++) push_word(CMD_PIXEL, 1'b1);
        push_word(CMD_PIXEL, 1'b0);
        push_word(CMD_PIXEL, 1'b1);
        push_word(CMD_DRAIN, 1'b0);
        push_word(CMD_DRAIN, 1'b1);
        push_word(CMD_DRAIN, 1'b0);
        wait_drained();

        // Width above the maximum, height below the minimum, sent with no
        // idling on either side: the frame is cut just after its first results.
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(2047));
        write_reg(CFG_IMAGE_HEIGHT, DIM_W'(0));
        @(negedge i_clk);
        gap_pct   = 0;
        stall_pct = 0;
        wv = clamp_dim(width_reg, MAX_WIDTH);
        for (int k = 0; k < wv + 8; k++) begin
            push_word(CMD_PIXEL, $urandom_range(99) < 90);
            random_items++;
        end
        wait_drained();
        gap_pct   = 27;
        stall_pct = 27;

        // Width below the minimum and height above the maximum, frame cut early.
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(2));
        write_reg(CFG_IMAGE_HEIGHT, DIM_W'(2047));
        @(negedge i_clk);
        for (int k = 0; k < 40; k++) begin
            push_word(CMD_PIXEL, $urandom_range(99) < 85);
            random_items++;
        end
        wait_drained();

        // Random phases of small frames; the sender pauses for all results
        // between phases.
        while (random_items < 1300) begin
            case ($urandom_range(9))
                0: wv = $urandom_range(2, 0);
                1: wv = $urandom_range(48, 13);
                default: wv = $urandom_range(12, 3);
            endcase
            if ($urandom_range(7) == 0) hv = $urandom_range(2, 0);
            else hv = $urandom_range(8, 3);
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(1) == 0) write_reg(CFG_IMAGE_WIDTH, DIM_W'(wv));
                else write_reg(CFG_IMAGE_HEIGHT, DIM_W'(hv));
            end else begin
                write_reg(CFG_IMAGE_WIDTH, DIM_W'(wv));
                write_reg(CFG_IMAGE_HEIGHT, DIM_W'(hv));
            end
            @(negedge i_clk);
            n_frames = $urandom_range(3, 1);
            for (int f = 0; f < n_frames; f++) begin
                push_frame(clamp_dim(width_reg, MAX_WIDTH), clamp_dim(height_reg, MAX_HEIGHT),
                           f == n_frames - 1 && $urandom_range(5) == 0);
            end
            wait_drained();
        end

        repeat (50) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bbe_pkg.sv
rtl/core/bbe_skid.sv
rtl/core/binary_boundary_extract_3x3.sv
verif/testbench.sv
